### sv/pip_pkg.sv
// Shared widths, register indexes and the multiply-accumulate command type.
package pip_pkg;

	localparam int LAT_W      = 31;
	localparam int LON_W      = 32;
	localparam int DLAT_W     = 32;
	localparam int DLON_W     = 33;
	localparam int VTX_W      = LAT_W + LON_W;
	localparam int HW_W       = 20;
	localparam int W2_W       = 2 * HW_W;
	localparam int OP_W       = 35;
	localparam int MP_W       = 2 * OP_W;
	localparam int ACC_W      = 140;
	localparam int SH_W       = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_LAT      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_LAT      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_LON      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_LON      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROUTE_MODE       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROUTE_HALF_WIDTH = 3'd5;

	typedef struct packed {
		logic                   valid;
		logic signed [OP_W-1:0] a;
		logic signed [OP_W-1:0] b;
		logic [SH_W-1:0]        shift;
		logic                   neg;
		logic                   clr;
	} mac_op_t;

endpackage

### sv/pip_if.sv
// Channel interfaces: query/load requests, results and configuration writes.
interface pip_req_if;
	logic                               valid;
	logic                               ready;
	logic                               kind;
	logic signed [pip_pkg::LAT_W-1:0]   lat;
	logic signed [pip_pkg::LON_W-1:0]   lon;
	logic                               last_vertex;
	modport source (output valid, kind, lat, lon, last_vertex, input ready);
	modport sink (input valid, kind, lat, lon, last_vertex, output ready);
endinterface

interface pip_rsp_if;
	logic valid;
	logic ready;
	logic inside_res;
	logic truncated;
	modport source (output valid, inside_res, truncated, input ready);
	modport sink (input valid, inside_res, truncated, output ready);
endinterface

interface pip_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [pip_pkg::CFG_IDX_W-1:0]     index;
	logic [pip_pkg::CFG_DATA_W-1:0]    data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### sv/point_in_polygon_or_route_test.sv
// Point-in-shape tester: a query walks the edges in polygon mode and the segments in route mode,
// its pace set by the one shared multiplier and the single read port of the vertex memory; one
// item is worked on at a time.
// A failed box test, an empty shape or a one-vertex route skips the walk and answers outside.
// Reset clears the vertex count and the overflow flag and marks the shape complete; the vertex
// memory is not cleared, since only entries below the count are ever read.
module point_in_polygon_or_route_test #(
	parameter int MAX_VERTICES = 256,
	parameter int ROUTE_BIAS   = 1000
) (
	input  logic      clk,
	input  logic      arst_n,
	pip_req_if.sink   req,
	pip_rsp_if.source rsp,
	pip_cfg_if.sink   cfg
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = AW + 1;

	localparam logic [5:0] S_IDLE  = 6'd0,  S_PRD_L = 6'd1,  S_PRD_F = 6'd2,  S_PCHK = 6'd3;
	localparam logic [5:0] S_RRD0  = 6'd4,  S_RGET0 = 6'd5,  S_ERD   = 6'd6,  S_EOPS = 6'd7;
	localparam logic [5:0] S_P0    = 6'd8,  S_P1    = 6'd9,  S_P2    = 6'd10;
	localparam logic [5:0] S_RL0   = 6'd11, S_RL1   = 6'd12, S_RLW   = 6'd13, S_RLC  = 6'd14;
	localparam logic [5:0] S_RD1   = 6'd15, S_RDW   = 6'd16, S_RDC   = 6'd17;
	localparam logic [5:0] S_RC1   = 6'd18, S_RCW   = 6'd19, S_RCC   = 6'd20;
	localparam logic [5:0] S_RQ0   = 6'd21, S_RQ1   = 6'd22, S_RQ2   = 6'd23, S_RQW  = 6'd24;
	localparam logic [5:0] S_RQC   = 6'd25, S_RM1   = 6'd26, S_RM2   = 6'd27, S_RM3  = 6'd28;
	localparam logic [5:0] S_RMW   = 6'd29, S_RMC   = 6'd30;
	localparam logic [5:0] S_NP    = 6'd31, S_NP1   = 6'd32, S_NPW   = 6'd33, S_NPC  = 6'd34;
	localparam logic [5:0] S_NEXT  = 6'd35, S_DONE  = 6'd36;

	localparam int AWD = pip_pkg::ACC_W;

	// configuration
	logic signed [pip_pkg::LAT_W-1:0] min_lat_q, max_lat_q;
	logic signed [pip_pkg::LON_W-1:0] min_lon_q, max_lon_q;
	logic                             route_q;
	logic [pip_pkg::HW_W-1:0]         hw_q;
	logic [pip_pkg::W2_W-1:0]         w2_q;

	// shape state
	logic [pip_pkg::VTX_W-1:0] mem [MAX_VERTICES];
	logic [pip_pkg::VTX_W-1:0] rd_q;
	logic [AW-1:0]             rd_addr;
	logic [CW-1:0]             count_q;
	logic                      complete_q;
	logic                      ovf_q;

	// query state
	logic [5:0]                       state_q;
	logic signed [pip_pkg::LAT_W-1:0] plat_q;
	logic signed [pip_pkg::LON_W-1:0] plon_q;
	logic [AW-1:0]                    idx_q;
	logic [pip_pkg::VTX_W-1:0]        prev_q, cur_q;
	logic signed [pip_pkg::DLON_W-1:0] x_q, u_q, x2_q;
	logic signed [pip_pkg::DLAT_W-1:0] y_q, v_q, y2_q;
	logic                             cond_q, par_q, np_end_q, res_q;
	logic signed [63:0]               lhs_q;
	logic [67:0]                      len2_q;
	logic [53:0]                      cr_q;
	logic [107:0]                     c2_q;
	logic                             out_valid_q, out_inside_q, out_trunc_q;

	pip_pkg::mac_op_t             op;
	logic signed [pip_pkg::MP_W-1:0] mp_s1;
	logic signed [AWD-1:0]        acc_q;

	pip_mac u_mac (.clk(clk), .arst_n(arst_n), .op(op), .mp_s1(mp_s1), .acc_q(acc_q));

	// helpers
	logic                             req_acc, load_acc, query_acc, box_ok;
	logic signed [33:0]               qlat, qlon, bias;
	logic [CW-1:0]                    cnt_eff;
	logic [AW-1:0]                    n_m1;
	logic signed [pip_pkg::LAT_W-1:0] rd_lat, prev_lat;
	logic signed [pip_pkg::LON_W-1:0] rd_lon, prev_lon;
	logic signed [33:0]               sel_x, sel_y;
	logic [33:0]                      dx, dy;
	logic signed [AWD-1:0]            cr_abs, len2_ext;
	logic signed [63:0]               rhs;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid_q;
	assign rsp.inside_res = out_inside_q;
	assign rsp.truncated = out_trunc_q;

	assign req_acc   = req.valid && req.ready;
	assign load_acc  = req_acc && !req.kind;
	assign query_acc = req_acc && req.kind;
	assign cnt_eff   = complete_q ? '0 : count_q;
	assign n_m1      = AW'(count_q - 1'b1);

	assign rd_lat   = rd_q[pip_pkg::VTX_W-1:pip_pkg::LON_W];
	assign rd_lon   = rd_q[pip_pkg::LON_W-1:0];
	assign prev_lat = prev_q[pip_pkg::VTX_W-1:pip_pkg::LON_W];
	assign prev_lon = prev_q[pip_pkg::LON_W-1:0];

	always_comb begin
		qlat = 34'(req.lat);
		qlon = 34'(req.lon);
		bias = 34'(ROUTE_BIAS);
		if (route_q) begin
			box_ok = (qlat > 34'(min_lat_q) - bias) && (qlat < 34'(max_lat_q) + bias) &&
			         (qlon > 34'(min_lon_q) - bias) && (qlon < 34'(max_lon_q) + bias);
		end else begin
			box_ok = (qlat >= 34'(min_lat_q)) && (qlat <= 34'(max_lat_q)) &&
			         (qlon >= 34'(min_lon_q)) && (qlon <= 34'(max_lon_q));
		end
	end

	always_comb begin
		sel_x    = np_end_q ? 34'(x2_q) : 34'(x_q);
		sel_y    = np_end_q ? 34'(y2_q) : 34'(y_q);
		dx       = sel_x[33] ? 34'(-sel_x) : 34'(sel_x);
		dy       = sel_y[33] ? 34'(-sel_y) : 34'(sel_y);
		cr_abs   = acc_q[AWD-1] ? -acc_q : acc_q;
		len2_ext = AWD'(len2_q);
		rhs      = mp_s1[63:0];
	end

	always_comb begin
		unique case (state_q)
			S_PRD_L: rd_addr = n_m1;
			S_PRD_F, S_RRD0: rd_addr = '0;
			default: rd_addr = idx_q;
		endcase
	end

	// multiplier command for each step
	always_comb begin
		op = '0;
		unique case (state_q)
			S_P0: begin
				op.valid = cond_q;
				op.a = 35'(x2_q);
				op.b = -35'(v_q);
			end
			S_P1: begin
				op.valid = 1'b1;
				op.a = -35'(u_q);
				op.b = 35'(y2_q);
			end
			S_RL0: begin
				op.valid = 1'b1; op.clr = 1'b1;
				op.a = 35'(u_q); op.b = 35'(u_q);
			end
			S_RL1: begin
				op.valid = 1'b1;
				op.a = 35'(v_q); op.b = 35'(v_q);
			end
			S_RLC: begin
				op.valid = (acc_q != '0); op.clr = 1'b1;
				op.a = 35'(x_q); op.b = 35'(u_q);
			end
			S_RD1: begin
				op.valid = 1'b1;
				op.a = 35'(y_q); op.b = 35'(v_q);
			end
			S_RDC: begin
				op.valid = 1'b1; op.clr = 1'b1;
				op.a = 35'(x_q); op.b = 35'(v_q);
			end
			S_RC1: begin
				op.valid = 1'b1; op.neg = 1'b1;
				op.a = 35'(y_q); op.b = 35'(u_q);
			end
			S_RQ0: begin
				op.valid = 1'b1; op.clr = 1'b1; op.shift = 7'd54;
				op.a = 35'(cr_q[53:27]); op.b = 35'(cr_q[53:27]);
			end
			S_RQ1: begin
				op.valid = 1'b1; op.shift = 7'd28;
				op.a = 35'(cr_q[53:27]); op.b = 35'(cr_q[26:0]);
			end
			S_RQ2: begin
				op.valid = 1'b1;
				op.a = 35'(cr_q[26:0]); op.b = 35'(cr_q[26:0]);
			end
			S_RQC: begin
				op.valid = 1'b1; op.clr = 1'b1;
				op.a = 35'(len2_q[33:0]); op.b = 35'(w2_q[33:0]);
			end
			S_RM1: begin
				op.valid = 1'b1; op.shift = 7'd34;
				op.a = 35'(len2_q[33:0]); op.b = 35'(w2_q[39:34]);
			end
			S_RM2: begin
				op.valid = 1'b1; op.shift = 7'd34;
				op.a = 35'(len2_q[67:34]); op.b = 35'(w2_q[33:0]);
			end
			S_RM3: begin
				op.valid = 1'b1; op.shift = 7'd68;
				op.a = 35'(len2_q[67:34]); op.b = 35'(w2_q[39:34]);
			end
			S_NP: begin
				op.valid = (dx < 34'(hw_q)) && (dy < 34'(hw_q)); op.clr = 1'b1;
				op.a = 35'(dx); op.b = 35'(dx);
			end
			S_NP1: begin
				op.valid = 1'b1;
				op.a = 35'(dy); op.b = 35'(dy);
			end
			default: op = '0;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_lat_q <= -31'sd900000000;
			max_lat_q <= 31'sd900000000;
			min_lon_q <= -32'sd1800000000;
			max_lon_q <= 32'sd1800000000;
			route_q   <= 1'b0;
			hw_q      <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				pip_pkg::REG_BOX_MIN_LAT:      min_lat_q <= cfg.data[pip_pkg::LAT_W-1:0];
				pip_pkg::REG_BOX_MAX_LAT:      max_lat_q <= cfg.data[pip_pkg::LAT_W-1:0];
				pip_pkg::REG_BOX_MIN_LON:      min_lon_q <= cfg.data;
				pip_pkg::REG_BOX_MAX_LON:      max_lon_q <= cfg.data;
				pip_pkg::REG_ROUTE_MODE:       route_q <= cfg.data[0];
				pip_pkg::REG_ROUTE_HALF_WIDTH: hw_q <= cfg.data[pip_pkg::HW_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		w2_q <= hw_q * hw_q;
	end

	// vertex memory
	always_ff @(posedge clk) begin
		if (load_acc && (cnt_eff < CW'(MAX_VERTICES)))
			mem[cnt_eff[AW-1:0]] <= {req.lat, req.lon};
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			complete_q <= 1'b1;
			ovf_q      <= 1'b0;
		end else if (load_acc) begin
			if (cnt_eff < CW'(MAX_VERTICES)) begin
				count_q <= cnt_eff + 1'b1;
				ovf_q   <= complete_q ? 1'b0 : ovf_q;
			end else begin
				count_q <= cnt_eff;
				ovf_q   <= 1'b1;
			end
			complete_q <= req.last_vertex;
		end
	end

	// query sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready && state_q != S_DONE) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (query_acc) begin
						if (!box_ok || count_q == '0 || (route_q && count_q == CW'(1))) begin
							res_q   <= 1'b0;
							state_q <= S_DONE;
						end else begin
							state_q <= route_q ? S_RRD0 : S_PRD_L;
						end
					end
				end
				S_PRD_L: state_q <= S_PRD_F;
				S_PRD_F: state_q <= S_PCHK;
				S_PCHK: begin
					if (prev_q != rd_q) begin
						res_q   <= 1'b0;
						state_q <= S_DONE;
					end else begin
						state_q <= S_ERD;
					end
				end
				S_RRD0:  state_q <= S_RGET0;
				S_RGET0: state_q <= S_ERD;
				S_ERD:   state_q <= S_EOPS;
				S_EOPS:  state_q <= route_q ? S_RL0 : S_P0;
				S_P0:    state_q <= cond_q ? S_P1 : S_NEXT;
				S_P1:    state_q <= S_P2;
				S_P2:    state_q <= S_NEXT;
				S_RL0:   state_q <= S_RL1;
				S_RL1:   state_q <= S_RLW;
				S_RLW:   state_q <= S_RLC;
				S_RLC:   state_q <= (acc_q == '0) ? S_NP : S_RD1;
				S_RD1:   state_q <= S_RDW;
				S_RDW:   state_q <= S_RDC;
				S_RDC: begin
					if (acc_q[AWD-1] || len2_ext < acc_q) state_q <= S_NP;
					else state_q <= S_RC1;
				end
				S_RC1:   state_q <= S_RCW;
				S_RCW:   state_q <= S_RCC;
				S_RCC:   state_q <= (cr_abs[AWD-1:54] != '0) ? S_NEXT : S_RQ0;
				S_RQ0:   state_q <= S_RQ1;
				S_RQ1:   state_q <= S_RQ2;
				S_RQ2:   state_q <= S_RQW;
				S_RQW:   state_q <= S_RQC;
				S_RQC:   state_q <= S_RM1;
				S_RM1:   state_q <= S_RM2;
				S_RM2:   state_q <= S_RM3;
				S_RM3:   state_q <= S_RMW;
				S_RMW:   state_q <= S_RMC;
				S_RMC: begin
					if (AWD'(c2_q) < $unsigned(acc_q)) begin
						res_q   <= 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_NP:    state_q <= op.valid ? S_NP1 : S_NEXT;
				S_NP1:   state_q <= S_NPW;
				S_NPW:   state_q <= S_NPC;
				S_NPC: begin
					if ($unsigned(acc_q) < AWD'(w2_q)) begin
						res_q   <= 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (idx_q == n_m1) begin
						res_q   <= route_q ? 1'b0 : par_q;
						state_q <= S_DONE;
					end else begin
						state_q <= S_ERD;
					end
				end
				S_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_inside_q <= res_q;
						out_trunc_q  <= ovf_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers of the sequencer
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				plat_q <= req.lat;
				plon_q <= req.lon;
				par_q  <= 1'b0;
				idx_q  <= '0;
			end
			S_PRD_F: prev_q <= rd_q;
			S_RGET0: begin
				prev_q <= rd_q;
				idx_q  <= AW'(1);
			end
			S_EOPS: begin
				cur_q  <= rd_q;
				x_q    <= 33'(plon_q) - 33'(prev_lon);
				y_q    <= 32'(plat_q) - 32'(prev_lat);
				u_q    <= 33'(rd_lon) - 33'(prev_lon);
				v_q    <= 32'(rd_lat) - 32'(prev_lat);
				x2_q   <= 33'(plon_q) - 33'(rd_lon);
				y2_q   <= 32'(plat_q) - 32'(rd_lat);
				cond_q <= (rd_lat <= plat_q && plat_q < prev_lat) ||
				          (prev_lat <= plat_q && plat_q < rd_lat);
			end
			S_P1: lhs_q <= mp_s1[63:0];
			S_P2: begin
				// edge runs downward when the current vertex lies below the previous one
				if (v_q < 0 ? (lhs_q < rhs) : (lhs_q > rhs)) par_q <= !par_q;
			end
			S_RLC: begin
				len2_q   <= acc_q[67:0];
				np_end_q <= 1'b0;
			end
			S_RDC: np_end_q <= !acc_q[AWD-1];
			S_RCC: cr_q <= cr_abs[53:0];
			S_RQC: c2_q <= acc_q[107:0];
			S_NEXT: begin
				prev_q <= cur_q;
				idx_q  <= idx_q + 1'b1;
			end
			default: ;
		endcase
	end

endmodule

### sv/pip_mac.sv
// Shared signed multiplier with a registered product and a shifting accumulator.
module pip_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pip_pkg::mac_op_t                    op,
	output logic signed [pip_pkg::MP_W-1:0]     mp_s1,
	output logic signed [pip_pkg::ACC_W-1:0]    acc_q
);

	logic                           valid_s1;
	logic [pip_pkg::SH_W-1:0]       shift_s1;
	logic                           neg_s1;
	logic                           clr_s1;
	logic signed [pip_pkg::ACC_W-1:0] term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= op.valid;
		end
	end

	always_ff @(posedge clk) begin
		mp_s1    <= op.a * op.b;
		shift_s1 <= op.shift;
		neg_s1   <= op.neg;
		clr_s1   <= op.clr;
	end

	always_comb begin
		term = pip_pkg::ACC_W'(mp_s1);
		term = term <<< shift_s1;
		if (neg_s1) term = -term;
	end

	always_ff @(posedge clk) begin
		if (valid_s1) acc_q <= (clr_s1 ? '0 : acc_q) + term;
	end

endmodule
